// File: rtl/dcr_pkg.sv
// Package for the distance constraint relaxation block.
// Holds register map, fixed field widths, FSM state, command and status types.
// No dependencies.
package dcr_pkg;

   localparam int MASS_WIDTH  = 16;
   localparam int STIFF_WIDTH = 17;
   localparam int DIST_WIDTH  = 23;
   localparam int BOUND_WIDTH = 13;
   localparam int RATIO_WIDTH = 24;
   localparam int RATIO_FRAC  = 16;
   localparam int STIFF_FRAC  = 16;
   localparam int K_WIDTH     = 25;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] REG_REST    = 3'd0;
   localparam logic [2:0] REG_STIFF   = 3'd1;
   localparam logic [2:0] REG_TEAR    = 3'd2;
   localparam logic [2:0] REG_TEAR_EN = 3'd3;
   localparam logic [2:0] REG_BOUND_W = 3'd4;
   localparam logic [2:0] REG_BOUND_H = 3'd5;

   localparam logic [DIST_WIDTH-1:0]  REST_RESET  = 23'd10240;
   localparam logic [STIFF_WIDTH-1:0] STIFF_RESET = 17'd65536;
   localparam logic [DIST_WIDTH-1:0]  TEAR_RESET  = 23'd8388607;
   localparam logic [BOUND_WIDTH-1:0] BW_RESET    = 13'd1920;
   localparam logic [BOUND_WIDTH-1:0] BH_RESET    = 13'd1080;

   typedef struct packed {
      logic [DIST_WIDTH-1:0]  rest_distance;
      logic [STIFF_WIDTH-1:0] stiffness;
      logic [DIST_WIDTH-1:0]  tear_distance;
      logic                   tearing_enabled;
      logic [BOUND_WIDTH-1:0] bound_width;
      logic [BOUND_WIDTH-1:0] bound_height;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_A, S_MUL_B, S_SUM, S_SQRT, S_DIVR, S_DIV1, S_RATIO,
      S_DIVS, S_DIV2, S_SPLIT, S_K1, S_K2, S_C1, S_C2, S_C3, S_C4, S_C5,
      S_BND, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_DXDX, MUL_DYDY, MUL_IM_STIFF, MUL_S1_RATIO, MUL_S2_RATIO,
      MUL_DX_K1, MUL_DY_K1, MUL_DX_K2, MUL_DY_K2
   } mul_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_SQ_A, CAP_SUM, CAP_RATIO, CAP_SPLIT, CAP_K1, CAP_K2,
      CAP_CFX, CAP_CFY, CAP_CSX, CAP_CSY, CAP_BOUNDS
   } cap_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      cap_sel_type cap;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        div_init_ratio;
      logic        div_init_split;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: rtl/distance_constraint_relax.sv
// Distance constraint relaxation for one cloth link per item.
// Input items arrive on the req_ stream: both link ends, inverse masses and
// the owning point's pin data; req_tlast marks the point's last link and
// req_tuser carries the pinned flag. Each result leaves on the rsp_ stream:
// corrected ends, the stretch ratio and, in rsp_tuser, the torn flag.
// Registers (rest, stiffness, tear length, tearing enable, bounds) sit on
// the csr_ APB port at byte addresses 0, 4, ... 20; write only while idle.
// One item is in flight at a time: the sequencer runs the multiplies, the
// bit-serial root and the two divisions in the shared divider, and takes
// the next item in the cycle after the result is loaded into the output
// register. A stalled rsp_ holds the result; the sequencer then waits with
// the next result until the output register is free. Reset clears the torn
// state, the output valid and loads the register defaults.
module distance_constraint_relax import dcr_pkg::*; #(
   parameter int POS_WIDTH = 24,
   parameter int FRAC_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_x, first_y, second_x, second_y, first_inv_mass, second_inv_mass,
   // pin_x, pin_y, zero fill
   input  logic [((6*POS_WIDTH+2*MASS_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   // pinned
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // new_first_x, new_first_y, new_second_x, new_second_y, stretch_ratio,
   // zero fill
   output logic [((4*POS_WIDTH+RATIO_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // torn
   output logic rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready
);
   localparam int P      = POS_WIDTH;
   localparam int RSP_W  = ((4*P+RATIO_WIDTH+7)/8)*8;
   localparam int RW     = P + 1;
   localparam int MGW    = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;
   localparam int DW     = MGW + RATIO_FRAC;
   localparam int CNT_W  = $clog2(DW + 1);
   localparam int M0     = 4 * P;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic signed [P-1:0] nfx, nfy, nsx, nsy;
   logic signed [RATIO_WIDTH-1:0] ratio;

   dcr_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   dcr_ctrl #(.SQRT_ITERS(RW), .DIV_ITERS(DW), .CNT_WIDTH(CNT_W)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_tvalid), .req_ready(req_tready),
      .status(status), .cmd(cmd)
   );

   dcr_dp #(.POS_WIDTH(POS_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .cfg(cfg),
      .first_x(req_tdata[P-1:0]),
      .first_y(req_tdata[2*P-1:P]),
      .second_x(req_tdata[3*P-1:2*P]),
      .second_y(req_tdata[4*P-1:3*P]),
      .first_inv_mass(req_tdata[M0+MASS_WIDTH-1:M0]),
      .second_inv_mass(req_tdata[M0+2*MASS_WIDTH-1:M0+MASS_WIDTH]),
      .last_link(req_tlast),
      .pinned(req_tuser),
      .pin_x(req_tdata[M0+2*MASS_WIDTH+P-1:M0+2*MASS_WIDTH]),
      .pin_y(req_tdata[M0+2*MASS_WIDTH+2*P-1:M0+2*MASS_WIDTH+P]),
      .new_first_x(nfx), .new_first_y(nfy),
      .new_second_x(nsx), .new_second_y(nsy),
      .stretch_ratio(ratio), .torn(rsp_tuser),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready)
   );

   assign rsp_tdata = RSP_W'({ratio, nsy, nsx, nfy, nfx});
endmodule

// File: rtl/dcr_csr.sv
// Configuration registers of the distance constraint relaxation block.
// APB-style write/read port; depends on dcr_pkg.
module dcr_csr import dcr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);
   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_REST:    cfg_in.rest_distance   = csr_pwdata[DIST_WIDTH-1:0];
            REG_STIFF:   cfg_in.stiffness       = csr_pwdata[STIFF_WIDTH-1:0];
            REG_TEAR:    cfg_in.tear_distance   = csr_pwdata[DIST_WIDTH-1:0];
            REG_TEAR_EN: cfg_in.tearing_enabled = csr_pwdata[0];
            REG_BOUND_W: cfg_in.bound_width     = csr_pwdata[BOUND_WIDTH-1:0];
            REG_BOUND_H: cfg_in.bound_height    = csr_pwdata[BOUND_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_REST:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.rest_distance);
         REG_STIFF:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.stiffness);
         REG_TEAR:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.tear_distance);
         REG_TEAR_EN: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.tearing_enabled);
         REG_BOUND_W: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.bound_width);
         REG_BOUND_H: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.bound_height);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_distance   <= REST_RESET;
         cfg_ff.stiffness       <= STIFF_RESET;
         cfg_ff.tear_distance   <= TEAR_RESET;
         cfg_ff.tearing_enabled <= 1'b0;
         cfg_ff.bound_width     <= BW_RESET;
         cfg_ff.bound_height    <= BH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: rtl/dcr_ctrl.sv
// Sequencer of the distance constraint relaxation block.
// Steps the datapath through multiply, root, divide and correct; uses dcr_pkg.
module dcr_ctrl import dcr_pkg::*; #(
   parameter int SQRT_ITERS = 25,
   parameter int DIV_ITERS  = 41,
   parameter int CNT_WIDTH  = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      req_ready          = 1'b0;
      cmd.load           = 1'b0;
      cmd.mul_sel        = MUL_DXDX;
      cmd.cap            = CAP_NONE;
      cmd.sqrt_init      = 1'b0;
      cmd.sqrt_step      = 1'b0;
      cmd.div_init_ratio = 1'b0;
      cmd.div_init_split = 1'b0;
      cmd.div_step       = 1'b0;
      cmd.out_load       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            cmd.mul_sel = MUL_DXDX;
            state_in    = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_sel = MUL_DYDY;
            cmd.cap     = CAP_SQ_A;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.cap       = CAP_SUM;
            cmd.sqrt_init = 1'b1;
            cnt_in        = CNT_WIDTH'(SQRT_ITERS);
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) state_in = S_DIVR;
         end
         S_DIVR: begin
            cmd.div_init_ratio = 1'b1;
            cnt_in             = CNT_WIDTH'(DIV_ITERS);
            state_in           = S_DIV1;
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) state_in = S_RATIO;
         end
         S_RATIO: begin
            cmd.cap     = CAP_RATIO;
            cmd.mul_sel = MUL_IM_STIFF;
            state_in    = S_DIVS;
         end
         S_DIVS: begin
            cmd.div_init_split = 1'b1;
            cnt_in             = CNT_WIDTH'(DIV_ITERS);
            state_in           = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) state_in = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.cap  = CAP_SPLIT;
            state_in = S_K1;
         end
         S_K1: begin
            cmd.mul_sel = MUL_S1_RATIO;
            state_in    = S_K2;
         end
         S_K2: begin
            cmd.mul_sel = MUL_S2_RATIO;
            cmd.cap     = CAP_K1;
            state_in    = S_C1;
         end
         S_C1: begin
            cmd.mul_sel = MUL_DX_K1;
            cmd.cap     = CAP_K2;
            state_in    = S_C2;
         end
         S_C2: begin
            cmd.mul_sel = MUL_DY_K1;
            cmd.cap     = CAP_CFX;
            state_in    = S_C3;
         end
         S_C3: begin
            cmd.mul_sel = MUL_DX_K2;
            cmd.cap     = CAP_CFY;
            state_in    = S_C4;
         end
         S_C4: begin
            cmd.mul_sel = MUL_DY_K2;
            cmd.cap     = CAP_CSX;
            state_in    = S_C5;
         end
         S_C5: begin
            cmd.cap  = CAP_CSY;
            state_in = S_BND;
         end
         S_BND: begin
            cmd.cap  = CAP_BOUNDS;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL_A))
      else $error("accepted item did not start");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_WIDTH'(DIV_ITERS))
      else $error("iteration count out of range");
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !status.out_free) |=> (state_ff == S_OUT))
      else $error("result dropped while output stalled");
endmodule

// File: rtl/dcr_dp.sv
// Datapath of the distance constraint relaxation block: shared multiplier,
// bit-serial root, restoring divider, correction, bounds and output stage.
// Depends on dcr_pkg; driven by dcr_ctrl.
module dcr_dp import dcr_pkg::*; #(
   parameter int POS_WIDTH = 24,
   parameter int FRAC_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  cfg_type                     cfg,
   input  logic signed [POS_WIDTH-1:0] first_x,
   input  logic signed [POS_WIDTH-1:0] first_y,
   input  logic signed [POS_WIDTH-1:0] second_x,
   input  logic signed [POS_WIDTH-1:0] second_y,
   input  logic [MASS_WIDTH-1:0]       first_inv_mass,
   input  logic [MASS_WIDTH-1:0]       second_inv_mass,
   input  logic                        last_link,
   input  logic                        pinned,
   input  logic signed [POS_WIDTH-1:0] pin_x,
   input  logic signed [POS_WIDTH-1:0] pin_y,
   output logic signed [POS_WIDTH-1:0] new_first_x,
   output logic signed [POS_WIDTH-1:0] new_first_y,
   output logic signed [POS_WIDTH-1:0] new_second_x,
   output logic signed [POS_WIDTH-1:0] new_second_y,
   output logic signed [RATIO_WIDTH-1:0] stretch_ratio,
   output logic                        torn,
   output logic                        rsp_valid,
   input  logic                        rsp_ready
);
   localparam int P   = POS_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int RW  = P + 1;
   localparam int MW  = (RW > K_WIDTH) ? RW : K_WIDTH;
   localparam int PW  = 2 * MW;
   localparam int SW  = 2 * P + 2;
   localparam int RMW = RW + 3;
   localparam int MGW = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;
   localparam int DW  = MGW + RATIO_FRAC;
   localparam int DVW = (RW > STIFF_WIDTH) ? RW : STIFF_WIDTH;
   localparam int CW  = PW - RATIO_FRAC + 2;
   localparam int EW  = ((P > BOUND_WIDTH + 1 + F) ? P : BOUND_WIDTH + 1 + F) + 3;
   localparam int RMAX = (1 << (RATIO_WIDTH - 1)) - 1;
   localparam int RMIN = 1 << (RATIO_WIDTH - 1);

   // input item
   logic signed [P-1:0] fx_ff, fy_ff, sx_ff, sy_ff, px_ff, py_ff;
   logic [MASS_WIDTH-1:0] im1_ff, im2_ff;
   logic last_ff, pin_ff;
   // working registers
   logic [PW-1:0]  prod_ff, prod_in;
   logic [PW-1:0]  sq_a_ff;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [DW-1:0]  q_ff, q_in;
   logic [DVW:0]   r_ff, r_in;
   logic [DVW-1:0] d_ff, d_in;
   logic           num_neg_ff;
   logic signed [RATIO_WIDTH-1:0] ratio_ff;
   logic           nocorr_ff, torn_ff, torn_in;
   logic [STIFF_WIDTH-1:0] s1_ff, s2_ff;
   logic [K_WIDTH-1:0] k1_ff, k2_ff;
   logic signed [P-1:0] nfx_ff, nfy_ff, nsx_ff, nsy_ff;
   logic signed [P-1:0] ofx_ff, ofy_ff, osx_ff, osy_ff;
   logic signed [RATIO_WIDTH-1:0] oratio_ff;
   logic otorn_ff, out_valid_ff;

   logic signed [RW-1:0] dx, dy;
   logic [RW-1:0]  adx, ady;
   logic [MW-1:0]  op_a, op_b;
   logic [RATIO_WIDTH-1:0] ratio_mag;
   logic           ratio_neg;
   logic [RMW-1:0] rem2, trial;
   logic           sq_ge;
   logic [DVW:0]   r2;
   logic           dv_ge;
   logic signed [MGW:0] num;
   logic [MGW-1:0] num_mag;
   logic [MASS_WIDTH:0] im_sum;
   logic signed [RATIO_WIDTH-1:0] ratio_val;
   logic           tear;
   logic [STIFF_WIDTH-1:0] s1_val;
   logic signed [P-1:0] c_base, c_res;
   logic           c_neg;
   logic [PW-RATIO_FRAC-1:0] c_mag;
   logic signed [CW-1:0] c_sum;
   logic signed [EW-1:0] one, wm1, hm1, by0, by1, by2, bx0, bx1, bx2;
   logic signed [P-1:0] by_sat, bx_sat;

   assign dx  = {fx_ff[P-1], fx_ff} - {sx_ff[P-1], sx_ff};
   assign dy  = {fy_ff[P-1], fy_ff} - {sy_ff[P-1], sy_ff};
   assign adx = dx[RW-1] ? RW'(-dx) : RW'(dx);
   assign ady = dy[RW-1] ? RW'(-dy) : RW'(dy);
   assign ratio_neg = ratio_ff[RATIO_WIDTH-1];
   assign ratio_mag = ratio_neg ? RATIO_WIDTH'(-ratio_ff) : RATIO_WIDTH'(ratio_ff);

   // shared multiplier, registered
   always_comb begin
      case (cmd.mul_sel)
         MUL_DXDX:     begin op_a = MW'(adx);    op_b = MW'(adx); end
         MUL_DYDY:     begin op_a = MW'(ady);    op_b = MW'(ady); end
         MUL_IM_STIFF: begin op_a = MW'(im1_ff); op_b = MW'(cfg.stiffness); end
         MUL_S1_RATIO: begin op_a = MW'(s1_ff);  op_b = MW'(ratio_mag); end
         MUL_S2_RATIO: begin op_a = MW'(s2_ff);  op_b = MW'(ratio_mag); end
         MUL_DX_K1:    begin op_a = MW'(adx);    op_b = MW'(k1_ff); end
         MUL_DY_K1:    begin op_a = MW'(ady);    op_b = MW'(k1_ff); end
         MUL_DX_K2:    begin op_a = MW'(adx);    op_b = MW'(k2_ff); end
         MUL_DY_K2:    begin op_a = MW'(ady);    op_b = MW'(k2_ff); end
         default:      begin op_a = '0;          op_b = '0; end
      endcase
      prod_in = PW'(op_a) * PW'(op_b);
   end

   // root, one result bit per step
   assign rem2  = {rem_ff[RMW-3:0], sum_ff[SW-1:SW-2]};
   assign trial = RMW'({root_ff, 2'b01});
   assign sq_ge = rem2 >= trial;

   always_comb begin
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.cap == CAP_SUM) begin
         sum_in = SW'(sq_a_ff) + SW'(prod_ff);
      end
      if (cmd.sqrt_init) begin
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         sum_in  = {sum_ff[SW-3:0], 2'b00};
         rem_in  = sq_ge ? rem2 - trial : rem2;
         root_in = {root_ff[RW-2:0], sq_ge};
      end
   end

   // restoring divider, one quotient bit per step
   assign num     = $signed({{(MGW+1-DIST_WIDTH){1'b0}}, cfg.rest_distance})
                    - $signed({{(MGW+1-RW){1'b0}}, root_ff});
   assign num_mag = num[MGW] ? MGW'(-num) : MGW'(num);
   assign im_sum  = {1'b0, im1_ff} + {1'b0, im2_ff};
   assign r2      = {r_ff[DVW-1:0], q_ff[DW-1]};
   assign dv_ge   = r2 >= {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      if (cmd.div_init_ratio) begin
         q_in = {num_mag, {RATIO_FRAC{1'b0}}};
         r_in = '0;
         d_in = DVW'(root_ff);
      end else if (cmd.div_init_split) begin
         q_in = DW'(prod_ff[STIFF_WIDTH+MASS_WIDTH-1:0]);
         r_in = '0;
         d_in = DVW'(im_sum);
      end else if (cmd.div_step) begin
         r_in = dv_ge ? r2 - {1'b0, d_ff} : r2;
         q_in = {q_ff[DW-2:0], dv_ge};
      end
   end

   // saturated ratio and tear test
   always_comb begin
      if (root_ff == '0) begin
         ratio_val = '0;
      end else if (!num_neg_ff) begin
         ratio_val = (q_ff > DW'(RMAX)) ? RATIO_WIDTH'(RMAX) : RATIO_WIDTH'(q_ff);
      end else begin
         ratio_val = (q_ff > DW'(RMIN)) ? RATIO_WIDTH'(RMIN) : RATIO_WIDTH'(-q_ff);
      end
      tear    = cfg.tearing_enabled && (MGW'(root_ff) > MGW'(cfg.tear_distance));
      torn_in = torn_ff;
      if (cmd.cap == CAP_RATIO) torn_in = torn_ff | tear;
      else if (cmd.out_load && last_ff) torn_in = 1'b0;
      s1_val  = (im_sum == '0) ? '0 : q_ff[STIFF_WIDTH-1:0];
   end

   // corrected position of one coordinate
   always_comb begin
      case (cmd.cap)
         CAP_CFX: begin c_base = fx_ff; c_neg = dx[RW-1] ^ ratio_neg; end
         CAP_CFY: begin c_base = fy_ff; c_neg = dy[RW-1] ^ ratio_neg; end
         CAP_CSX: begin c_base = sx_ff; c_neg = ~(dx[RW-1] ^ ratio_neg); end
         CAP_CSY: begin c_base = sy_ff; c_neg = ~(dy[RW-1] ^ ratio_neg); end
         default: begin c_base = fx_ff; c_neg = 1'b0; end
      endcase
      c_mag = prod_ff[PW-1:RATIO_FRAC];
      c_sum = CW'(c_base) + (c_neg ? -$signed({2'b00, c_mag}) : $signed({2'b00, c_mag}));
      if (nocorr_ff) c_res = c_base;
      else if (c_sum > CW'(signed'({1'b0, {(P-1){1'b1}}}))) c_res = {1'b0, {(P-1){1'b1}}};
      else if (c_sum < -CW'(signed'({1'b0, {(P-1){1'b1}}})) - 1) c_res = {1'b1, {(P-1){1'b0}}};
      else c_res = c_sum[P-1:0];
   end

   // reflection at the screen bounds
   always_comb begin
      one = EW'(1) <<< F;
      wm1 = (EW'(cfg.bound_width) <<< F) - one;
      hm1 = (EW'(cfg.bound_height) <<< F) - one;
      by0 = EW'(nfy_ff);
      by1 = (by0 < one) ? (one <<< 1) - by0 : by0;
      by2 = (by1 > hm1) ? (hm1 <<< 1) - by1 : by1;
      bx0 = EW'(nfx_ff);
      bx1 = (bx0 > wm1) ? (wm1 <<< 1) - bx0 : bx0;
      bx2 = (bx1 < one) ? (one <<< 1) - bx1 : bx1;
      if (by2 > EW'(signed'({1'b0, {(P-1){1'b1}}}))) by_sat = {1'b0, {(P-1){1'b1}}};
      else if (by2 < -EW'(signed'({1'b0, {(P-1){1'b1}}})) - 1) by_sat = {1'b1, {(P-1){1'b0}}};
      else by_sat = by2[P-1:0];
      if (bx2 > EW'(signed'({1'b0, {(P-1){1'b1}}}))) bx_sat = {1'b0, {(P-1){1'b1}}};
      else if (bx2 < -EW'(signed'({1'b0, {(P-1){1'b1}}})) - 1) bx_sat = {1'b1, {(P-1){1'b0}}};
      else bx_sat = bx2[P-1:0];
   end

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         torn_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         torn_ff      <= torn_in;
         out_valid_ff <= cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      if (cmd.load) begin
         fx_ff   <= first_x;
         fy_ff   <= first_y;
         sx_ff   <= second_x;
         sy_ff   <= second_y;
         px_ff   <= pin_x;
         py_ff   <= pin_y;
         im1_ff  <= first_inv_mass;
         im2_ff  <= second_inv_mass;
         last_ff <= last_link;
         pin_ff  <= pinned;
      end
      if (cmd.div_init_ratio) num_neg_ff <= num[MGW];
      case (cmd.cap)
         CAP_SQ_A:  sq_a_ff <= prod_ff;
         CAP_RATIO: begin
            ratio_ff  <= ratio_val;
            nocorr_ff <= (torn_ff | tear) | (root_ff == '0);
         end
         CAP_SPLIT: begin
            s1_ff <= s1_val;
            s2_ff <= (im_sum == '0) ? '0 : cfg.stiffness - s1_val;
         end
         CAP_K1:  k1_ff  <= prod_ff[STIFF_FRAC +: K_WIDTH];
         CAP_K2:  k2_ff  <= prod_ff[STIFF_FRAC +: K_WIDTH];
         CAP_CFX: nfx_ff <= c_res;
         CAP_CFY: nfy_ff <= c_res;
         CAP_CSX: nsx_ff <= c_res;
         CAP_CSY: nsy_ff <= c_res;
         CAP_BOUNDS: begin
            if (last_ff) begin
               nfx_ff <= pin_ff ? px_ff : bx_sat;
               nfy_ff <= pin_ff ? py_ff : by_sat;
            end
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         ofx_ff    <= nfx_ff;
         ofy_ff    <= nfy_ff;
         osx_ff    <= nsx_ff;
         osy_ff    <= nsy_ff;
         oratio_ff <= ratio_ff;
         otorn_ff  <= torn_ff;
      end
   end

   assign new_first_x   = ofx_ff;
   assign new_first_y   = ofy_ff;
   assign new_second_x  = osx_ff;
   assign new_second_y  = osy_ff;
   assign stretch_ratio = oratio_ff;
   assign torn          = otorn_ff;
   assign rsp_valid     = out_valid_ff;
endmodule

// File: tb/distance_constraint_relax_check.sv
// Checker for the distance constraint relaxation block: watches the req_ and
// rsp_ streams and the csr_ port, predicts each result and compares it.
// Depends on dcr_pkg.
`timescale 1ns / 100ps

module distance_constraint_relax_check import dcr_pkg::*; #(
   parameter int POS_WIDTH = 24,
   parameter int FRAC_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [((6*POS_WIDTH+2*MASS_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [((4*POS_WIDTH+RATIO_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic csr_pready,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      longint nfx, nfy, nsx, nsy, ratio;
      bit     torn;
   } link_result;

   link_result expected_links[$];
   longint rest_len, stiff, tear_len;
   bit     tear_en, torn_seen;
   longint bw, bh;

   assign pending = expected_links.size();

   function automatic longint sx_pos(logic [POS_WIDTH-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint scaled(longint a, longint b, int sh);
      longint unsigned p;
      p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned root_floor(logic [64:0] v);
      logic [64:0] r, rem, trial;
      r = 0;
      rem = 0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | ((v >> (2 * i)) & 65'd3);
         trial = (r << 2) | 65'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            r = (r << 1) | 65'd1;
         end else begin
            r = r << 1;
         end
      end
      return r[63:0];
   endfunction

   function automatic link_result relax_link(logic [$bits(req_tdata)-1:0] d,
                                             bit last, bit pin);
      link_result res;
      longint fx, fy, sx, sy, px, py, dx, dy, num, s1, s2, k1, k2, one, w, h;
      longint unsigned im1, im2, link_len, q, sum;
      logic [64:0] sq;
      fx = sx_pos(d[0 +: POS_WIDTH]);
      fy = sx_pos(d[POS_WIDTH +: POS_WIDTH]);
      sx = sx_pos(d[2*POS_WIDTH +: POS_WIDTH]);
      sy = sx_pos(d[3*POS_WIDTH +: POS_WIDTH]);
      im1 = d[4*POS_WIDTH +: MASS_WIDTH];
      im2 = d[4*POS_WIDTH+MASS_WIDTH +: MASS_WIDTH];
      px = sx_pos(d[4*POS_WIDTH+2*MASS_WIDTH +: POS_WIDTH]);
      py = sx_pos(d[5*POS_WIDTH+2*MASS_WIDTH +: POS_WIDTH]);
      dx = fx - sx;
      dy = fy - sy;
      sq = 65'(dx * dx) + 65'(dy * dy);
      link_len = root_floor(sq);
      res.ratio = 0;
      res.nfx = fx; res.nfy = fy; res.nsx = sx; res.nsy = sy;
      if (link_len != 0) begin
         num = rest_len - longint'(link_len);
         q = ((num < 0 ? -num : num) << RATIO_FRAC) / link_len;
         res.ratio = clamp(num < 0 ? -longint'(q) : longint'(q), RATIO_WIDTH);
      end
      if (tear_en && link_len > tear_len) torn_seen = 1;
      if (!torn_seen && link_len != 0) begin
         sum = im1 + im2;
         s1 = 0;
         s2 = 0;
         if (sum != 0) begin
            s1 = longint'((im1 * stiff) / sum);
            s2 = stiff - s1;
         end
         k1 = scaled(s1, res.ratio, STIFF_FRAC);
         k2 = scaled(s2, res.ratio, STIFF_FRAC);
         res.nfx = fx + scaled(dx, k1, RATIO_FRAC);
         res.nfy = fy + scaled(dy, k1, RATIO_FRAC);
         res.nsx = sx - scaled(dx, k2, RATIO_FRAC);
         res.nsy = sy - scaled(dy, k2, RATIO_FRAC);
      end
      res.nfx = clamp(res.nfx, POS_WIDTH);
      res.nfy = clamp(res.nfy, POS_WIDTH);
      res.nsx = clamp(res.nsx, POS_WIDTH);
      res.nsy = clamp(res.nsy, POS_WIDTH);
      res.torn = torn_seen;
      if (last) begin
         one = longint'(1) <<< FRAC_BITS;
         w = bw * one;
         h = bh * one;
         if (res.nfy < one) res.nfy = 2 * one - res.nfy;
         if (res.nfy > h - one) res.nfy = 2 * (h - one) - res.nfy;
         if (res.nfx > w - one) res.nfx = 2 * (w - one) - res.nfx;
         if (res.nfx < one) res.nfx = 2 * one - res.nfx;
         res.nfx = clamp(res.nfx, POS_WIDTH);
         res.nfy = clamp(res.nfy, POS_WIDTH);
         if (pin) begin
            res.nfx = px;
            res.nfy = py;
         end
         torn_seen = 0;
      end
      return res;
   endfunction

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      link_result e;
      if (reset) begin
         rest_len = 10240; stiff = 65536; tear_len = 8388607; tear_en = 0;
         bw = 1920; bh = 1080; torn_seen = 0;
         expected_links.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_REST:    rest_len = csr_pwdata[DIST_WIDTH-1:0];
               REG_STIFF:   stiff = csr_pwdata[STIFF_WIDTH-1:0];
               REG_TEAR:    tear_len = csr_pwdata[DIST_WIDTH-1:0];
               REG_TEAR_EN: tear_en = csr_pwdata[0];
               REG_BOUND_W: bw = csr_pwdata[BOUND_WIDTH-1:0];
               REG_BOUND_H: bh = csr_pwdata[BOUND_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_links.push_back(relax_link(req_tdata, req_tlast, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_links.size() == 0) begin
               $error("unexpected item on rsp_");
               fail_count++;
            end else begin
               e = expected_links.pop_front();
               compare_field("new_first_x", e.nfx, sx_pos(rsp_tdata[0 +: POS_WIDTH]));
               compare_field("new_first_y", e.nfy,
                             sx_pos(rsp_tdata[POS_WIDTH +: POS_WIDTH]));
               compare_field("new_second_x", e.nsx,
                             sx_pos(rsp_tdata[2*POS_WIDTH +: POS_WIDTH]));
               compare_field("new_second_y", e.nsy,
                             sx_pos(rsp_tdata[3*POS_WIDTH +: POS_WIDTH]));
               compare_field("stretch_ratio", e.ratio,
                  longint'(signed'(rsp_tdata[4*POS_WIDTH +: RATIO_WIDTH])));
               compare_field("torn", e.torn, rsp_tuser);
            end
         end
      end
   end

endmodule

// File: tb/distance_constraint_relax_test.sv
// Top of the distance constraint relaxation testbench: clock, reset, register
// phases and link stimulus; verdict from the checker.
// Depends on dcr_pkg, distance_constraint_relax and its checker.
`timescale 1ns / 100ps

module distance_constraint_relax_test;
   import dcr_pkg::*;

   localparam int PW = 24;
   localparam int REQ_W = ((6*PW+2*MASS_WIDTH+7)/8)*8;
   localparam int RSP_W = ((4*PW+RATIO_WIDTH+7)/8)*8;
   localparam int DRAIN = 200;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready, req_tlast = 0, req_tuser = 0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0, csr_prdata;
   int fail_count, pending;
   bit calm;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   distance_constraint_relax uut (.*);
   distance_constraint_relax_check checker_i (.*);

   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 10);

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= v;
      @(negedge clock) csr_penable <= 1;
      @(negedge clock) begin
         csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      end
      @(negedge clock);
   endtask

   task automatic send_link(logic [23:0] fx, fy, sx, sy, logic [15:0] m1, m2,
                            bit last, pin, logic [23:0] px, py);
      while (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'({py, px, m2, m1, sy, sx, fy, fx});
      req_tlast <= last; req_tuser <= pin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   function automatic logic [23:0] rnd_pos(int spread);
      case ($urandom_range(3))
         0: return 24'($urandom);
         default: return 24'(int'($urandom_range(2*spread)) - spread + 500000);
      endcase
   endfunction

   task automatic random_links(int n);
      logic [23:0] fx, fy;
      int run;
      run = 0;
      for (int i = 0; i < n; i++) begin
         if (run == 0) begin
            run = $urandom_range(1, 6);
            fx = rnd_pos(400000); fy = rnd_pos(400000);
         end
         run--;
         send_link(fx, fy, fx + 24'(int'($urandom_range(40000)) - 20000),
                   fy + 24'(int'($urandom_range(40000)) - 20000),
                   $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(8192)),
                   $urandom_range(15) == 0 ? 16'd0 : 16'($urandom),
                   run == 0, $urandom_range(3) == 0, 24'($urandom), 24'($urandom));
         if ($urandom_range(15) == 0)
            send_link(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      16'($urandom), 16'($urandom), $urandom_range(1),
                      $urandom_range(1), 24'($urandom), 24'($urandom));
      end
   endtask

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: extremes, zero length, zero masses, tearing, bounds, pin
      send_link(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF,
                1, 0, 0, 0);
      send_link(24'd5000, 24'd5000, 24'd5000, 24'd5000, 16'd100, 16'd100, 1, 0, 0, 0);
      send_link(24'd5000, 24'd5000, 24'd9000, 24'd2000, 16'd0, 16'd0, 1, 0, 0, 0);
      send_link(24'h800000, 24'd0, 24'd100, 24'd0, 16'd4096, 16'd0, 0, 0, 0, 0);
      send_link(24'd10, 24'd10, 24'd20, 24'd20, 16'd4096, 16'd4096, 1, 1,
                24'h7FFFFF, 24'h800000);
      send_link(24'd3000000, 24'd2000000, 24'd3000500, 24'd2000000, 16'd1, 16'hFFFF,
                1, 0, 0, 0);
      send_link(24'd1, 24'd1, 24'd2, 24'd2, 16'd10, 16'd20, 1, 0, 0, 0);
      drain_results();
      write_reg(REG_TEAR_EN, 1);
      write_reg(REG_TEAR, 20000);
      write_reg(REG_REST, 0);
      write_reg(REG_STIFF, 0);
      write_reg(REG_BOUND_W, 2);
      write_reg(REG_BOUND_H, 2);
      send_link(24'd100, 24'd100, 24'd50000, 24'd0, 16'd1000, 16'd1000, 0, 0, 0, 0);
      send_link(24'd100, 24'd100, 24'd200, 24'd0, 16'd1000, 16'd1000, 0, 0, 0, 0);
      send_link(24'd5000, 24'd100, 24'd200, 24'd0, 16'd1000, 16'd1000, 1, 0, 0, 0);
      send_link(24'd100, 24'd100, 24'd300, 24'd0, 16'd1000, 16'd1000, 1, 0, 0, 0);
      random_links(300);
      drain_results();
      write_reg(REG_REST, 23'h7FFFFF);
      write_reg(REG_STIFF, 17'd65536);
      write_reg(REG_TEAR, 23'h7FFFFF);
      write_reg(REG_BOUND_W, 8191);
      write_reg(REG_BOUND_H, 8191);
      random_links(300);
      drain_results();
      write_reg(REG_REST, 10240);
      write_reg(REG_STIFF, 17'd40000);
      write_reg(REG_TEAR, 15000);
      write_reg(REG_BOUND_W, 1920);
      write_reg(REG_BOUND_H, 1080);
      calm = 1;
      random_links(200);
      calm = 0;
      random_links(600);
      drain_results();
      write_reg(REG_TEAR_EN, 0);
      write_reg(REG_STIFF, 17'd65535);
      random_links(500);
      drain_results();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
rtl/dcr_pkg.sv
rtl/dcr_csr.sv
rtl/dcr_ctrl.sv
rtl/dcr_dp.sv
rtl/distance_constraint_relax.sv
tb/distance_constraint_relax_check.sv
tb/distance_constraint_relax_test.sv
